// ===== src/motion_object_list_walker_defines.svh =====
// Assertion macros used by the checker file.
// No dependencies.
`ifndef MOTION_OBJECT_LIST_WALKER_DEFINES_SVH
`define MOTION_OBJECT_LIST_WALKER_DEFINES_SVH
// Assert that an antecedent implies a consequent on the next clock.
`define MOLW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
// Assert that an antecedent implies a consequent in the same clock.
`define MOLW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`endif

// ===== src/molw_pkg.sv =====
// Package for the motion object list walker: types, constants, opcodes.
// No dependencies.
`timescale 1ns / 1ps
package molw_pkg;
   localparam int NumObjectsDef     = 64;
   localparam int SpriteRamWordsDef = 1024;
   localparam int ListEntriesDef    = 2048;
   localparam logic [15:0] SkipMark = 16'hFFFF;
   localparam int NumRegs = 7;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_BUILD = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      REG_STRIDE = 3'd0,
      REG_STEP   = 3'd1,
      REG_IGN    = 3'd2,
      REG_LSEL   = 3'd3,
      REG_LSHIFT = 3'd4,
      REG_LMASK  = 3'd5,
      REG_LIMIT  = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [10:0] address;
      logic [15:0] write_data;
      logic [5:0]  start_link;
      logic [8:0]  scanline;
   } req_type;

   typedef struct packed {
      logic [8:0]  entry_scanline;
      logic [63:0] entry_words;
      logic [11:0] group_start;
      logic [6:0]  group_count;
      logic [11:0] list_end;
      logic        advanced;
      logic        overflow;
   } rsp_type;

   typedef struct packed {
      logic [4:0]  object_stride;
      logic [8:0]  word_step;
      logic [1:0]  ignore_word_sel;
      logic [2:0]  link_word_sel;
      logic [3:0]  link_shift;
      logic [5:0]  link_mask;
      logic [11:0] list_limit;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_OP, ST_RD_WAIT, ST_READ_DONE, ST_B_INIT, ST_B_TAG, ST_OBJ,
      ST_WORD, ST_CMP, ST_NEXT, ST_FINISH, ST_EMIT
   } state_type;
endpackage

// ===== src/molw_if.sv =====
// Valid/ready channel interface carrying a payload of parameterized type.
// Depends on nothing.
`timescale 1ns / 1ps
interface molw_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== src/motion_object_list_walker.sv =====
// Top level of the motion object list walker: config registers, front, back.
// Depends on molw_pkg, molw_if, molw_front, molw_back.
`timescale 1ns / 1ps
// Motion object list walker. Requests come in on req_, results leave on rsp_,
// one result per item. A sprite RAM write or a list read holds the back end
// until its result is taken. A build reads the tag of the previous group
// start when a previous group exists, then walks each object in turn
// (four serial reads of the single sprite RAM port, then a compare/append
// on the list RAM port), and wraps up. A two-entry queue in front takes
// items while the back end works. Config writes on csr_ are taken at any
// time but must come while idle.
module motion_object_list_walker import molw_pkg::*; #(
   parameter int NumObjects     = NumObjectsDef,
   parameter int SpriteRamWords = SpriteRamWordsDef,
   parameter int ListEntries    = ListEntriesDef
) (
   input  logic  clock,
   input  logic  reset,
   molw_if.sink   req,
   molw_if.source rsp,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data
);
   cfg_type cfg_ff, cfg_in;
   logic    q_valid, q_ready;
   req_type q_data;

   assign csr_ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_STRIDE: cfg_in.object_stride   = csr_data[4:0];
            REG_STEP:   cfg_in.word_step       = csr_data[8:0];
            REG_IGN:    cfg_in.ignore_word_sel = csr_data[1:0];
            REG_LSEL:   cfg_in.link_word_sel   = csr_data[2:0];
            REG_LSHIFT: cfg_in.link_shift      = csr_data[3:0];
            REG_LMASK:  cfg_in.link_mask       = csr_data[5:0];
            REG_LIMIT:  cfg_in.list_limit      = csr_data[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{5'd4, 9'd1, 2'd0, 3'd4, 4'd0, 6'd63, 12'd2048};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   molw_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data));

   molw_back #(
      .NumObjects(NumObjects), .SpriteRamWords(SpriteRamWords),
      .ListEntries(ListEntries)
   ) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data));
endmodule

// ===== src/molw_ram.sv =====
// Generic single-port RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module molw_ram #(
   parameter int Width = 16,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

// ===== src/molw_front.sv =====
// Front end: accepts request items and queues them for the back end.
// Depends on molw_pkg.
`timescale 1ns / 1ps
module molw_front import molw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    q_valid,
   input  logic    q_ready,
   output req_type q_data
);
   // two-entry queue
   req_type    slot_ff [2];
   req_type    slot_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_data   = slot_ff[0];

   always_comb begin
      slot_in = slot_ff;
      cnt_in  = cnt_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
         cnt_in     = cnt_in - 2'd1;
      end
      if (push) begin
         slot_in[cnt_in[0]] = in_data;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot_ff <= slot_in;
   end
endmodule

// ===== src/molw_back.sv =====
// Back end: carries out writes, reads and list builds over the RAMs; a no-op just emits a result.
// Depends on molw_pkg and molw_ram.
`timescale 1ns / 1ps
module molw_back import molw_pkg::*; #(
   parameter int NumObjects     = NumObjectsDef,
   parameter int SpriteRamWords = SpriteRamWordsDef,
   parameter int ListEntries    = ListEntriesDef
) (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    q_valid,
   output logic    q_ready,
   input  req_type q_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);
   localparam int SAW = $clog2(SpriteRamWords);
   localparam int LAW = $clog2(ListEntries);
   localparam int OBW = $clog2(NumObjects);
   localparam int LW  = LAW + 1;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic [NumObjects-1:0] visit_ff, visit_in;
   logic [LW-1:0] len_ff, len_in, pstart_ff, pstart_in;
   logic          pvalid_ff, pvalid_in;
   logic [LW-1:0] d_ff, d_in, first_ff, first_in, kept_ff, kept_in;
   logic          match_ff, match_in, ovf_ff, ovf_in;
   logic [OBW-1:0] link_ff, link_in;
   logic [1:0]    k_ff, k_in;
   logic [63:0]   pk_ff, pk_in;
   logic [SAW-1:0] base_ff, base_in;
   logic [LW-1:0] limit;

   // RAM ports
   logic           s_we;
   logic [SAW-1:0] s_addr;
   logic [15:0]    s_rd;
   logic           l_we;
   logic [LAW-1:0] l_addr;
   logic [72:0]    l_wd, l_rd;

   molw_ram #(.Width(16), .Depth(SpriteRamWords)) u_sprite (
      .clock(clock), .we(s_we), .addr(s_addr), .wdata(req_ff.write_data), .rdata(s_rd));
   molw_ram #(.Width(73), .Depth(ListEntries)) u_list (
      .clock(clock), .we(l_we), .addr(l_addr), .wdata(l_wd), .rdata(l_rd));

   always_comb begin
      if (32'(cfg.list_limit) > 32'(ListEntries))
         limit = LW'(ListEntries);
      else
         limit = LW'(cfg.list_limit);
   end

   logic [63:0] pk_full;
   logic [LW-1:0] cmp_idx;
   always_comb begin
      pk_full = pk_ff;
      pk_full[48 +: 16] = s_rd;
      cmp_idx = pstart_ff + kept_ff;
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff; rsp_in = rsp_ff; visit_in = visit_ff;
      len_in = len_ff; pstart_in = pstart_ff; pvalid_in = pvalid_ff;
      d_in = d_ff; first_in = first_ff; kept_in = kept_ff;
      match_in = match_ff; ovf_in = ovf_ff; link_in = link_ff;
      k_in = k_ff; pk_in = pk_ff; base_in = base_ff;
      q_ready = 1'b0; out_valid = 1'b0;
      s_we = 1'b0; s_addr = req_ff.address[SAW-1:0];
      l_we = 1'b0; l_addr = req_ff.address[LAW-1:0];
      l_wd = {req_ff.scanline, pk_ff};
      unique case (state_ff)
         ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               req_in = q_data;
               state_in = ST_OP;
            end
         end
         ST_OP: begin
            rsp_in = '0;
            rsp_in.list_end = 12'(len_ff);
            unique case (opcode_type'(req_ff.opcode))
               OP_WRITE: begin
                  s_we = 1'b1;
                  state_in = ST_EMIT;
               end
               OP_READ: state_in = ST_RD_WAIT;
               OP_BUILD: begin
                  if (req_ff.scanline == '0) begin
                     len_in = '0; pvalid_in = 1'b0;
                  end
                  state_in = ST_B_INIT;
               end
               default: state_in = ST_EMIT;
            endcase
         end
         ST_RD_WAIT: state_in = ST_READ_DONE;
         ST_READ_DONE: begin
            rsp_in.entry_scanline = l_rd[72:64];
            rsp_in.entry_words = l_rd[63:0];
            state_in = ST_EMIT;
         end
         ST_B_INIT: begin
            // read tag of previous group start
            l_addr = pstart_ff[LAW-1:0];
            visit_in = '0; kept_in = '0; ovf_in = 1'b0;
            match_in = 1'b0;
            link_in = OBW'(req_ff.start_link);
            d_in = len_ff; first_in = len_ff;
            state_in = pvalid_ff ? ST_B_TAG : ST_OBJ;
         end
         ST_B_TAG: begin
            if (l_rd[72:64] == req_ff.scanline) begin
               d_in = pstart_ff; first_in = pstart_ff;
            end else begin
               match_in = 1'b1;
            end
            state_in = ST_OBJ;
         end
         ST_OBJ: begin
            if (visit_ff[link_ff]) begin
               state_in = ST_FINISH;
            end else if (d_ff >= limit) begin
               ovf_in = 1'b1; state_in = ST_FINISH;
            end else begin
               base_in = SAW'(32'(link_ff) * 32'(cfg.object_stride));
               s_addr = SAW'(32'(link_ff) * 32'(cfg.object_stride));
               k_in = 2'd0;
               state_in = ST_WORD;
            end
         end
         ST_WORD: begin
            // s_rd holds word k; issue the next address
            pk_in[16*k_ff +: 16] = s_rd;
            s_addr = SAW'(32'(base_ff) + 32'(k_ff + 2'd1) * 32'(cfg.word_step));
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd2) begin
               state_in = ST_CMP;
               l_addr = cmp_idx[LAW-1:0];
            end
         end
         ST_CMP: begin
            pk_in = pk_full;
            l_addr = cmp_idx[LAW-1:0];
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            visit_in[link_ff] = 1'b1;
            if (pk_ff[16*cfg.ignore_word_sel +: 16] != SkipMark) begin
               l_we = 1'b1; l_addr = d_ff[LAW-1:0];
               if (match_ff && (cmp_idx >= len_ff || l_rd[63:0] != pk_ff))
                  match_in = 1'b0;
               d_in = d_ff + LW'(1); kept_in = kept_ff + LW'(1);
            end
            if (cfg.link_word_sel[2])
               link_in = OBW'((6'(link_ff) + 6'd1) & cfg.link_mask);
            else
               link_in = OBW'(6'(pk_ff[16*cfg.link_word_sel[1:0] +: 16] >> cfg.link_shift)
                         & cfg.link_mask);
            state_in = ST_OBJ;
         end
         ST_FINISH: begin
            if (!match_ff) begin
               len_in = d_ff; pstart_in = first_ff; pvalid_in = 1'b1;
            end
            rsp_in.group_start = 12'(first_ff);
            rsp_in.group_count = 7'(kept_ff);
            rsp_in.list_end = match_ff ? 12'(len_ff) : 12'(d_ff);
            rsp_in.advanced = !match_ff;
            rsp_in.overflow = ovf_ff;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            out_valid = 1'b1;
            if (out_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign out_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         visit_ff <= '0;
         len_ff <= '0; pstart_ff <= '0; pvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         visit_ff <= visit_in;
         len_ff <= len_in; pstart_ff <= pstart_in; pvalid_ff <= pvalid_in;
      end
      req_ff <= req_in; rsp_ff <= rsp_in;
      d_ff <= d_in; first_ff <= first_in; kept_ff <= kept_in;
      match_ff <= match_in; ovf_ff <= ovf_in; link_ff <= link_in;
      k_ff <= k_in; pk_ff <= pk_in; base_ff <= base_in;
   end
endmodule

// ===== src/molw_checker.sv =====
// Port-level checker for the list walker, bound to the top level.
// Depends on molw_pkg and the defines header.
`timescale 1ns / 1ps
`include "motion_object_list_walker_defines.svh"
module molw_checker import molw_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   `MOLW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `MOLW_ASSERT_NOW(a_adv_ovf, clock, reset, rsp_valid && rsp_data.overflow, rsp_data.group_count != 7'd127)
   `MOLW_ASSERT_NOW(a_read_clean, clock, reset, rsp_valid && rsp_data.entry_words != 64'd0, !rsp_data.advanced && rsp_data.group_count == 7'd0)
endmodule

bind motion_object_list_walker molw_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));
